// File: hw/rtl/sliding_window_moving_average_core_macros.svh
// assertion macros shared by the moving average checker
`ifndef SLIDING_WINDOW_MOVING_AVERAGE_CORE_MACROS_SVH
`define SLIDING_WINDOW_MOVING_AVERAGE_CORE_MACROS_SVH

// same-cycle implication, off while reset is high
`define SWMA_ASSERT_IMPLY(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("moving average check failed");

// next-cycle implication, off while reset is high
`define SWMA_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("moving average check failed");

// next-cycle implication that also runs through reset
`define SWMA_ASSERT_ALWAYS_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) (ante) |=> (cons)) \
      else $error("moving average reset check failed");

`endif

// File: hw/rtl/swma_pkg.sv
// shared constants and controller/datapath types for the moving average core
package swma_pkg;

   // sizing
   localparam int MAX_WINDOW    = 1024;
   localparam int SAMPLE_BITS   = 18;
   localparam int FRACTION_BITS = 8;
   localparam int PTR_BITS      = $clog2(MAX_WINDOW);
   localparam int COUNT_BITS    = PTR_BITS + 1;
   localparam int CFG_BITS      = 11;
   localparam int AVG_BITS      = 26;

   // running sum and divider widths
   localparam int SUM_BITS      = SAMPLE_BITS + PTR_BITS + 1;
   localparam int MAG_BITS      = SUM_BITS - 1;
   localparam int DIVIDEND_BITS = MAG_BITS + FRACTION_BITS;
   localparam int DIV_STEPS     = DIVIDEND_BITS;
   localparam int STEP_BITS     = $clog2(DIV_STEPS + 1);

   // commands from the controller
   typedef struct packed {
      logic load;
      logic update;
      logic div_start;
      logic out_load;
   } ctrl_cmd_type;

   // status back to the controller
   typedef struct packed {
      logic div_done;
   } dp_status_type;

endpackage

// File: hw/rtl/swma_req_if.sv
// sample input channel
interface swma_req_if;
   import swma_pkg::*;

   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] sample;

   modport source (output valid, output sample, input ready);
   modport sink   (input valid, input sample, output ready);
endinterface

// File: hw/rtl/swma_rsp_if.sv
// average result channel
interface swma_rsp_if;
   import swma_pkg::*;

   logic                       valid;
   logic                       ready;
   logic signed [AVG_BITS-1:0] average_q8;
   logic [COUNT_BITS-1:0]      samples_in_window;

   modport source (output valid, output average_q8, output samples_in_window, input ready);
   modport sink   (input valid, input average_q8, input samples_in_window, output ready);
endinterface

// File: hw/rtl/swma_div.sv
// radix-2 restoring divider, one quotient bit per cycle
module swma_div (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  logic [swma_pkg::DIVIDEND_BITS-1:0]  dividend,
   input  logic [swma_pkg::COUNT_BITS-1:0]     divisor,
   output logic                                done,
   output logic [swma_pkg::DIVIDEND_BITS-1:0]  quotient
);
   import swma_pkg::*;

   logic [DIVIDEND_BITS-1:0] quo_ff, quo_in;
   logic [COUNT_BITS-1:0]    rem_ff, rem_in;
   logic [STEP_BITS-1:0]     cnt_ff, cnt_in;
   logic                     busy_ff, busy_in;
   logic                     done_ff, done_in;
   logic [COUNT_BITS:0]      trial;
   logic                     fits;

   // one shift-and-subtract step
   always_comb begin
      trial   = {rem_ff, quo_ff[DIVIDEND_BITS-1]};
      fits    = trial >= {1'b0, divisor};
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         cnt_in  = STEP_BITS'(DIV_STEPS);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         quo_in = {quo_ff[DIVIDEND_BITS-2:0], fits};
         rem_in = fits ? COUNT_BITS'(trial - {1'b0, divisor}) : trial[COUNT_BITS-1:0];
         cnt_in = cnt_ff - STEP_BITS'(1);
         if (cnt_ff == STEP_BITS'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // control flops
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;
endmodule

// File: hw/rtl/swma_datapath.sv
// ring buffer, running sum, window state and result register
module swma_datapath (
   input  logic                                 clock,
   input  logic                                 reset,
   input  swma_pkg::ctrl_cmd_type               cmd,
   output swma_pkg::dp_status_type              status,
   input  logic                                 csr_wr_en,
   input  logic [swma_pkg::CFG_BITS-1:0]        csr_wr_data,
   input  logic signed [swma_pkg::SAMPLE_BITS-1:0] sample,
   output logic signed [swma_pkg::AVG_BITS-1:0] average_q8,
   output logic [swma_pkg::COUNT_BITS-1:0]      samples_in_window
);
   import swma_pkg::*;

   logic [SAMPLE_BITS-1:0]        ring_mem [MAX_WINDOW];

   logic [COUNT_BITS-1:0]         window_ff, window_in;
   logic [COUNT_BITS-1:0]         fill_ff, fill_in;
   logic [PTR_BITS-1:0]           oldest_ff, oldest_in;
   logic signed [SUM_BITS-1:0]    sum_ff, sum_in;
   logic signed [SUM_BITS-1:0]    old_ext;

   logic signed [SAMPLE_BITS-1:0] sample_ff;
   logic signed [SAMPLE_BITS-1:0] old_ff;
   logic [PTR_BITS-1:0]           pos_ff, pos_in;
   logic                          full_ff, full_in;
   logic                          neg_ff;

   logic [MAG_BITS-1:0]           mag;
   logic [DIVIDEND_BITS-1:0]      dividend;
   logic [DIVIDEND_BITS-1:0]      quotient;
   logic                          div_done;
   logic [AVG_BITS-1:0]           quo_low;
   logic [AVG_BITS-1:0]           avg_ff, avg_in;
   logic [COUNT_BITS-1:0]         count_ff;

   // window size saturates into one to the maximum
   always_comb begin
      window_in = COUNT_BITS'(csr_wr_data);
      if (csr_wr_data == '0) begin
         window_in = COUNT_BITS'(1);
      end else if (csr_wr_data > CFG_BITS'(MAX_WINDOW)) begin
         window_in = COUNT_BITS'(MAX_WINDOW);
      end
   end

   // slot for the new sample: next free slot while filling, else the oldest
   assign full_in = (fill_ff == window_ff);
   assign pos_in  = full_in ? oldest_ff : fill_ff[PTR_BITS-1:0];

   // sum and pointer update for the captured sample
   always_comb begin
      old_ext = full_ff ? SUM_BITS'(old_ff) : '0;
      sum_in  = sum_ff + SUM_BITS'(sample_ff) - old_ext;
      fill_in = full_ff ? fill_ff : fill_ff + COUNT_BITS'(1);
      oldest_in = oldest_ff;
      if (full_ff) begin
         oldest_in = (COUNT_BITS'(pos_ff) == window_ff - COUNT_BITS'(1)) ? '0
                                                                         : pos_ff + PTR_BITS'(1);
      end
   end

   // window state, cleared by reset and by any window size write
   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff <= COUNT_BITS'(1);
         fill_ff   <= '0;
         oldest_ff <= '0;
         sum_ff    <= '0;
      end else if (csr_wr_en) begin
         window_ff <= window_in;
         fill_ff   <= '0;
         oldest_ff <= '0;
         sum_ff    <= '0;
      end else if (cmd.update) begin
         fill_ff   <= fill_in;
         oldest_ff <= oldest_in;
         sum_ff    <= sum_in;
      end
   end

   // ring write
   always_ff @(posedge clock) begin
      if (cmd.update) begin
         ring_mem[pos_ff] <= sample_ff;
      end
   end

   // ring read of the slot about to be replaced
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         old_ff <= ring_mem[pos_in];
      end
   end

   // beat capture
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         sample_ff <= sample;
         pos_ff    <= pos_in;
         full_ff   <= full_in;
      end
   end

   // magnitude of the sum, scaled to the fixed-point grid
   assign mag      = sum_ff[SUM_BITS-1] ? MAG_BITS'(-sum_ff) : MAG_BITS'(sum_ff);
   assign dividend = DIVIDEND_BITS'(mag) << FRACTION_BITS;

   always_ff @(posedge clock) begin
      if (cmd.div_start) begin
         neg_ff <= sum_ff[SUM_BITS-1];
      end
   end

   swma_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (dividend),
      .divisor  (fill_ff),
      .done     (div_done),
      .quotient (quotient)
   );

   assign status.div_done = div_done;

   // sign restored after the magnitude division, truncating toward zero
   assign quo_low = quotient[AVG_BITS-1:0];
   assign avg_in  = neg_ff ? -quo_low : quo_low;

   // result register
   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         avg_ff   <= avg_in;
         count_ff <= fill_ff;
      end
   end

   assign average_q8        = avg_ff;
   assign samples_in_window = count_ff;
endmodule

// File: hw/rtl/swma_ctrl.sv
// sequencing state machine and result valid flag
module swma_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   input  swma_pkg::dp_status_type status,
   output swma_pkg::ctrl_cmd_type  cmd
);
   import swma_pkg::*;

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_UPDATE = 3'd1;
   localparam logic [2:0] S_START  = 3'd2;
   localparam logic [2:0] S_DIV    = 3'd3;
   localparam logic [2:0] S_DONE   = 3'd4;

   logic [2:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       out_free;

   assign out_free = !rsp_valid_ff || rsp_ready;

   // next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_UPDATE;
            end
         end
         S_UPDATE: begin
            cmd.update = 1'b1;
            state_in   = S_START;
         end
         S_START: begin
            cmd.div_start = 1'b1;
            state_in      = S_DIV;
         end
         S_DIV: begin
            if (status.div_done) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (out_free) begin
               cmd.out_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // result beat held until taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
endmodule

// File: hw/rtl/sliding_window_moving_average_core.sv
// a sample passes the update, start, divide and done states to its result beat
// no new sample is taken until then; the divider is radix-2 with 36 steps
// a result waiting in the output register does not hold off the next sample
// reset (synchronous): window size 1, empty window, zero sum, no result pending
// ring contents are not cleared; an entry is only read after it was rewritten
module sliding_window_moving_average_core (
   input  logic                          clock,
   input  logic                          reset,
   swma_req_if.sink                      req_bus,
   swma_rsp_if.source                    rsp_bus,
   input  logic                          csr_wr_en,
   input  logic [swma_pkg::CFG_BITS-1:0] csr_wr_data
);
   import swma_pkg::*;

   ctrl_cmd_type          cmd;
   dp_status_type         status;
   logic                  req_valid;
   logic                  req_ready;
   logic                  rsp_valid;
   logic                  rsp_ready;
   logic [COUNT_BITS-1:0] rsp_count;

   // channel wiring
   assign req_valid                 = req_bus.valid;
   assign req_bus.ready             = req_ready;
   assign rsp_ready                 = rsp_bus.ready;
   assign rsp_bus.valid             = rsp_valid;
   assign rsp_bus.samples_in_window = rsp_count;

   swma_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   swma_datapath u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .csr_wr_en         (csr_wr_en),
      .csr_wr_data       (csr_wr_data),
      .sample            (req_bus.sample),
      .average_q8        (rsp_bus.average_q8),
      .samples_in_window (rsp_count)
   );
endmodule

// File: hw/rtl/swma_checker.sv
// port-level checks for the moving average core, bound to the top level
`include "sliding_window_moving_average_core_macros.svh"

module swma_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_valid,
   input logic                              req_ready,
   input logic                              rsp_valid,
   input logic                              rsp_ready,
   input logic [swma_pkg::COUNT_BITS-1:0]   samples_in_window
);
   import swma_pkg::*;

   logic count_ok;

   // a result beat stays offered until taken
   `SWMA_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid)

   // one sample in flight: no new beat right after an accepted one
   `SWMA_ASSERT_NEXT(a_one_in_flight, req_valid && req_ready, !req_ready)

   // the count on a result lies within the window limits
   assign count_ok = (samples_in_window != '0) &&
                     (samples_in_window <= COUNT_BITS'(MAX_WINDOW));
   `SWMA_ASSERT_IMPLY(a_count_range, rsp_valid, count_ok)

   // reset leaves no result pending and the input open
   `SWMA_ASSERT_ALWAYS_NEXT(a_reset_state, reset, !rsp_valid && req_ready)
endmodule

bind sliding_window_moving_average_core swma_checker u_swma_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_valid),
   .req_ready         (req_ready),
   .rsp_valid         (rsp_valid),
   .rsp_ready         (rsp_ready),
   .samples_in_window (rsp_count)
);
